[hdl/shc_pkg.sv]
// ----------------------------------------------------------------------------
// shc_pkg
// shared types and constants of the symbol histogram / cumulative table block
// ----------------------------------------------------------------------------
package shc_pkg;

  localparam int SymInW       = 8;
  localparam int CountOutW    = 32;
  localparam int BlockWordsW  = 25;
  localparam int FillW        = 24;
  localparam int QueueDepth   = 2;

  localparam logic [BlockWordsW-1:0] BlockWordsReset = 25'd4096;
  localparam logic [BlockWordsW-1:0] FillMax         = 25'h100_0000;
  localparam logic [BlockWordsW-1:0] FillMin         = 25'd1;

  // mode field codes
  localparam logic ModeCount = 1'b0;
  localparam logic ModeEmit  = 1'b1;

  typedef enum logic {
    OP_COUNT,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_state_e;

  typedef struct packed {
    logic                mode;
    logic [SymInW-1:0]   symbol;
  } in_item_t;

  typedef struct packed {
    logic [SymInW-1:0]    symbol_index;
    logic [CountOutW-1:0] frequency;
    logic [CountOutW-1:0] cumulative;
    logic                 last_entry;
    logic [SymInW-1:0]    largest_symbol;
    logic [CountOutW-1:0] total_symbols;
    logic [CountOutW-1:0] block_count;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic [SymInW-1:0] symbol;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_head_t;

  typedef struct packed {
    logic clearing;
    logic busy;
    logic ptr_zero;
  } back_status_t;

endpackage

[hdl/shc_ram.sv]
// ----------------------------------------------------------------------------
// shc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module shc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/shc_front.sv]
// ----------------------------------------------------------------------------
// shc_front
// accepts input beats, decodes the mode and queues them for the back end
// ----------------------------------------------------------------------------
module shc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  shc_pkg::in_item_t   in_data_i,
  input  logic                hold_i,
  input  logic                pop_i,
  output shc_pkg::queue_head_t head_o
);
  import shc_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  queue_item_t       entry_q [QueueDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  queue_item_t       decoded;
  logic              push, pop;

  always_comb begin
    decoded.symbol = in_data_i.symbol;
    unique case (in_data_i.mode)
      ModeCount: decoded.op = OP_COUNT;
      ModeEmit:  decoded.op = OP_EMIT;
      default:   decoded.op = OP_COUNT;
    endcase
  end

  assign in_stall_o = hold_i || (cnt_q == CntFull);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntOne;
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= decoded;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = entry_q[rptr_q];

endmodule

[hdl/shc_back.sv]
// ----------------------------------------------------------------------------
// shc_back
// histogram ram, totals and table readout with the output register
// ----------------------------------------------------------------------------
module shc_back #(
  parameter int SYMBOL_BITS = 8,
  parameter int COUNT_BITS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [shc_pkg::BlockWordsW-1:0]      cfg_wdata_i,
  input  shc_pkg::queue_head_t                 head_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output shc_pkg::out_item_t                   out_data_o,
  output shc_pkg::back_status_t                status_o
);
  import shc_pkg::*;

  localparam int Depth = 1 << SYMBOL_BITS;
  localparam logic [SYMBOL_BITS-1:0] SymLast = {SYMBOL_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  CntMax  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  CntOne  = COUNT_BITS'(1);

  back_state_e               state_q, state_d;
  logic [BlockWordsW-1:0]    block_words_q;
  logic [SYMBOL_BITS-1:0]    clr_addr_q;
  logic [SYMBOL_BITS-1:0]    largest_q;
  logic [COUNT_BITS-1:0]     total_q;
  logic [FillW-1:0]          fill_q;
  logic [COUNT_BITS-1:0]     blocks_q;
  logic [SYMBOL_BITS-1:0]    ptr_q;
  logic [COUNT_BITS-1:0]     sum_q;
  op_e                       op_q;
  logic [SYMBOL_BITS-1:0]    sym_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic                      ram_we, ram_re;
  logic [SYMBOL_BITS-1:0]    ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0]     ram_wdata, ram_rdata;

  logic [15:0]               head_sym_wide;
  logic [SYMBOL_BITS-1:0]    head_sym;
  logic                      drop, issue, do_count, do_emit, out_free, is_last;
  logic [BlockWordsW-1:0]    limit, fill_inc;
  logic [COUNT_BITS-1:0]     freq_inc;
  logic [COUNT_BITS:0]       sum_wide;
  logic [15:0]               ptr_wide, largest_wide;

  assign head_sym_wide = 16'(head_i.item.symbol);
  assign head_sym      = head_sym_wide[SYMBOL_BITS-1:0];

  // a count beat is ignored while the table is being read out
  assign drop     = head_i.valid && (head_i.item.op == OP_COUNT) && (ptr_q != '0);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = (ptr_q >= largest_q);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == SymLast) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_i.valid && !drop) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_q == OP_COUNT || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------ outputs
  always_comb begin
    pop_o     = 1'b0;
    issue     = 1'b0;
    do_count  = 1'b0;
    do_emit   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = sym_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
      end
      ST_IDLE: begin
        pop_o = head_i.valid;
        if (head_i.valid && !drop) begin
          issue     = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = (head_i.item.op == OP_COUNT) ? head_sym : ptr_q;
        end
      end
      ST_EXEC: begin
        if (op_q == OP_COUNT) begin
          do_count  = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = sym_q;
          ram_wdata = freq_inc;
        end else if (out_free) begin
          do_emit   = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = ptr_q;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ datapath
  always_comb begin
    if (block_words_q == '0) begin
      limit = FillMin;
    end else if (block_words_q > FillMax) begin
      limit = FillMax;
    end else begin
      limit = block_words_q;
    end
  end

  assign fill_inc = {1'b0, fill_q} + BlockWordsW'(1);
  assign freq_inc = (ram_rdata == CntMax) ? CntMax : ram_rdata + CntOne;
  assign sum_wide = {1'b0, sum_q} + {1'b0, ram_rdata};
  assign ptr_wide     = 16'(ptr_q);
  assign largest_wide = 16'(largest_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      block_words_q <= BlockWordsReset;
      clr_addr_q    <= '0;
      largest_q     <= '0;
      total_q       <= '0;
      fill_q        <= '0;
      blocks_q      <= '0;
      ptr_q         <= '0;
      sum_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) block_words_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + SYMBOL_BITS'(1);
      if (do_count) begin
        if (sym_q > largest_q) largest_q <= sym_q;
        if (total_q != CntMax) total_q <= total_q + CntOne;
        if (fill_q == '0 && blocks_q != CntMax) blocks_q <= blocks_q + CntOne;
        fill_q <= (fill_inc >= limit) ? '0 : fill_inc[FillW-1:0];
      end
      if (do_emit) begin
        if (is_last) begin
          largest_q <= '0;
          total_q   <= '0;
          fill_q    <= '0;
          blocks_q  <= '0;
          ptr_q     <= '0;
          sum_q     <= '0;
        end else begin
          sum_q <= sum_wide[COUNT_BITS] ? CntMax : sum_wide[COUNT_BITS-1:0];
          ptr_q <= ptr_q + SYMBOL_BITS'(1);
        end
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      op_q  <= head_i.item.op;
      sym_q <= head_sym;
    end
    if (do_emit) begin
      out_q.symbol_index   <= ptr_wide[SymInW-1:0];
      out_q.frequency      <= CountOutW'(ram_rdata);
      out_q.cumulative     <= CountOutW'(sum_q);
      out_q.last_entry     <= is_last;
      out_q.largest_symbol <= largest_wide[SymInW-1:0];
      out_q.total_symbols  <= CountOutW'(total_q);
      out_q.block_count    <= CountOutW'(blocks_q);
    end
  end

  shc_ram #(
    .Width (COUNT_BITS),
    .Depth (Depth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.clearing = (state_q == ST_CLEAR);
  assign status_o.busy     = (state_q == ST_EXEC);
  assign status_o.ptr_zero = (ptr_q == '0);

endmodule

[hdl/symbol_histogram_cumulative.sv]
// ----------------------------------------------------------------------------
// symbol_histogram_cumulative
// frequency and cumulative frequency table builder for an ans coder
// ----------------------------------------------------------------------------
// Count beats (mode 0) add one symbol to a histogram held in a ram of
// 2**SYMBOL_BITS words and update the largest symbol, the symbol total and
// the block count; emit beats (mode 1) read the table out entry by entry
// from symbol 0 to the largest symbol, clearing each entry as it goes and
// resetting all totals after the entry marked last. Every beat that reaches
// the histogram first issues the ram read, then writes the updated word
// back and, for an emit, loads the output register. A count beat arriving
// during readout is discarded. An emit waits while the previous result is
// still held by a stalled output. A two-entry queue in front lets input
// beats keep arriving while the back end works. After reset the histogram
// ram is cleared one word per cycle, during which the input is stalled;
// config writes are taken at any time.
module symbol_histogram_cumulative #(
  parameter int SYMBOL_BITS = 8,
  parameter int COUNT_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [shc_pkg::BlockWordsW-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  shc_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output shc_pkg::out_item_t              out_data_o
);
  import shc_pkg::*;

  queue_head_t  head;
  logic         pop;
  back_status_t status;

  shc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .hold_i     (status.clearing),
    .pop_i      (pop),
    .head_o     (head)
  );

  shc_back #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

  // no beat gets in while the histogram is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> in_stall_o)
    else $error("input accepted during histogram clear");

  // a shown last entry means the readout pointer is back at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_entry) |-> status.ptr_zero)
    else $error("readout pointer not reset after last entry");

  // a new result only comes from an executing beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(status.busy))
    else $error("result appeared without an executing beat");

endmodule
